/* rtl/rma_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and sizes of the register map allocator.
package rma_pkg;

	localparam int RMA_NUM_REGS = 18;
	localparam int RMA_NUM_VARS = 256;

	localparam int RMA_CMD_W    = 2;
	localparam int RMA_VAR_W    = 8;
	localparam int RMA_KIND_W   = 2;
	localparam int RMA_REG_W    = 5;
	localparam int RMA_OFF_W    = 11;
	localparam int RMA_SEED_W   = 16;
	localparam int RMA_SLOT_W   = 8;
	localparam int RMA_ENTRY_W  = RMA_SLOT_W + 1;
	localparam int RMA_RECIP_SHIFT = 21;
	localparam int RMA_RECIP_W     = RMA_RECIP_SHIFT;

	localparam logic [RMA_SEED_W-1:0] RMA_LFSR_MASK  = 16'hB400;
	localparam logic [RMA_SEED_W-1:0] RMA_LFSR_RESET = 16'h0001;

	localparam logic [RMA_CMD_W-1:0] CMD_ENSURE       = 2'd0;
	localparam logic [RMA_CMD_W-1:0] CMD_ENSURE_AVOID = 2'd1;
	localparam logic [RMA_CMD_W-1:0] CMD_FLUSH        = 2'd2;
	localparam logic [RMA_CMD_W-1:0] CMD_CLEAR_MAP    = 2'd3;

	localparam logic [RMA_KIND_W-1:0] KIND_STORE   = 2'd0;
	localparam logic [RMA_KIND_W-1:0] KIND_LOAD    = 2'd1;
	localparam logic [RMA_KIND_W-1:0] KIND_ANSWER  = 2'd2;
	localparam logic [RMA_KIND_W-1:0] KIND_FLUSHED = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_FIX,
		ST_VSEL,
		ST_ALLOC,
		ST_MOD,
		ST_WAIT,
		ST_EMIT,
		ST_ANSWER,
		ST_FSCAN,
		ST_FDONE
	} rma_state_t;

	typedef enum logic [1:0] {
		PH_VICTIM,
		PH_LOAD,
		PH_FLUSH
	} rma_phase_t;

	typedef struct packed {
		logic start;
		logic reseed;
	} rma_div_ctl_t;

	typedef struct packed {
		logic                 done;
		logic [RMA_REG_W-1:0] rem;
	} rma_div_st_t;

endpackage

/* rtl/rma_if.sv */
`timescale 1ns / 1ps
// Handshake channels for request items and result items.
interface rma_in_if import rma_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [RMA_CMD_W-1:0] cmd;
	logic [RMA_VAR_W-1:0] var_id;
	logic                 is_write;
	logic [RMA_VAR_W-1:0] avoid_var_id;

	modport source (output valid, cmd, var_id, is_write, avoid_var_id, input ready);
	modport sink (input valid, cmd, var_id, is_write, avoid_var_id, output ready);
endinterface

interface rma_out_if import rma_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [RMA_KIND_W-1:0]       kind;
	logic [RMA_REG_W-1:0]        reg_index;
	logic                        use_zero;
	logic signed [RMA_OFF_W-1:0] frame_offset;
	logic                        last;

	modport source (output valid, kind, reg_index, use_zero, frame_offset, last, input ready);
	modport sink (input valid, kind, reg_index, use_zero, frame_offset, last, output ready);
endinterface

/* rtl/rma_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/rma_victim_div.sv */
`timescale 1ns / 1ps
// Victim LFSR and reciprocal-multiply unit that reduces it modulo the register count.
module rma_victim_div import rma_pkg::*; #(
	parameter int NUM_REGS = RMA_NUM_REGS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rma_div_ctl_t          ctl,
	input  logic [RMA_SEED_W-1:0] seed,
	output rma_div_st_t           st
);

	localparam int RIW       = $clog2(NUM_REGS);
	localparam int PW        = RMA_SEED_W + RMA_RECIP_W;
	localparam int RECIP_INT = ((1 << RMA_RECIP_SHIFT) + NUM_REGS - 1) / NUM_REGS;
	localparam logic [RMA_RECIP_W-1:0] RECIP = RMA_RECIP_W'(RECIP_INT);
	localparam logic [RMA_SEED_W-1:0]  NR    = RMA_SEED_W'(NUM_REGS);

	logic [RMA_SEED_W-1:0] lfsr_q;
	logic [RMA_SEED_W-1:0] lfsr_next;
	logic [PW-1:0]         prod;
	logic [RMA_SEED_W-1:0] back;
	logic [RMA_SEED_W-1:0] diff;
	logic [RMA_SEED_W-1:0] quo_q;
	logic [RIW-1:0]        rem_q;
	logic                  quo_go_q;
	logic                  rem_go_q;
	logic                  done_q;

	// The quotient comes from a multiply by the rounded-up reciprocal, exact for 16-bit values.
	assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? RMA_LFSR_MASK : '0);
	assign prod      = PW'(lfsr_q) * PW'(RECIP);
	assign back      = quo_q * NR;
	assign diff      = lfsr_q - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q   <= RMA_LFSR_RESET;
			quo_go_q <= 1'b0;
			rem_go_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (ctl.reseed) begin
				lfsr_q <= (seed == '0) ? RMA_LFSR_RESET : seed;
			end else if (ctl.start) begin
				lfsr_q <= lfsr_next;
			end
			quo_go_q <= ctl.start;
			rem_go_q <= quo_go_q;
			done_q   <= rem_go_q;
		end
	end

	always_ff @(posedge clk) begin
		if (quo_go_q) begin
			quo_q <= prod[PW-1:RMA_RECIP_SHIFT];
		end
		if (rem_go_q) begin
			rem_q <= diff[RIW-1:0];
		end
	end

	assign st.done = done_q;
	assign st.rem  = RMA_REG_W'(rem_q);

endmodule

/* rtl/register_map_allocator.sv */
`timescale 1ns / 1ps
// Top level: register map allocator with its sequencer, register map and slot table.
//
//  channel   direction  handshake              payload
//  request   in         request.valid/ready    cmd, var_id, is_write, avoid_var_id
//  result    out        result.valid/ready     kind, reg_index, use_zero, frame_offset, last
//  cfg       in         cfg_we                 cfg_wdata (victim seed)
//
// After reset all NUM_VARS entries of the slot table are cleared before the first item is taken.
// An item is taken only in the idle state; a clear command is carried out there and gives no result.
// An ensure scans up to NUM_REGS register entries one per cycle; a victim choice goes through the
// remainder unit and the victim select, and each slot lookup reduces the id below NUM_VARS
// in the MOD state and reads the slot table in the WAIT state. A flush scans all NUM_REGS entries.
// Each result waits in the output register until taken, which stalls the sequencer.
module register_map_allocator import rma_pkg::*; #(
	parameter int NUM_REGS = RMA_NUM_REGS,
	parameter int NUM_VARS = RMA_NUM_VARS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rma_in_if.sink                request,
	rma_out_if.source             result,
	input  logic                  cfg_we,
	input  logic [RMA_SEED_W-1:0] cfg_wdata
);

	localparam int RIW = $clog2(NUM_REGS);
	localparam int AW  = $clog2(NUM_VARS);
	localparam logic [RIW-1:0]       LAST_REG = RIW'(NUM_REGS - 1);
	localparam logic [AW-1:0]        LAST_VAR = AW'(NUM_VARS - 1);
	localparam logic [12:0]          NV_CMP   = 13'(NUM_VARS);
	localparam logic [RMA_VAR_W-1:0] NV_SUB   = RMA_VAR_W'(NUM_VARS);

	rma_state_t state_q, state_d;
	rma_phase_t phase_q;

	logic [RMA_VAR_W-1:0]  owner_q [NUM_REGS];
	logic [NUM_REGS-1:0]   dirty_q;
	logic [RMA_SLOT_W-1:0] next_slot_q;
	logic [AW-1:0]         clr_q;
	logic [RMA_SEED_W-1:0] seed_q;

	logic [RMA_CMD_W-1:0]  cmd_q;
	logic [RMA_VAR_W-1:0]  var_q;
	logic                  wr_q;
	logic [RMA_VAR_W-1:0]  avar_q;
	logic                  zero_q;
	logic [RIW-1:0]        idx_q;
	logic                  free_found_q;
	logic [RIW-1:0]        free_idx_q;
	logic                  avoid_found_q;
	logic [RIW-1:0]        avoid_idx_q;
	logic [RMA_VAR_W-1:0]  svar_q;
	logic [RMA_OFF_W-1:0]  off_q;

	logic                  out_valid_q;
	logic [RMA_KIND_W-1:0] out_kind_q;
	logic [RMA_REG_W-1:0]  out_reg_q;
	logic                  out_zero_q;
	logic [RMA_OFF_W-1:0]  out_off_q;
	logic                  out_last_q;

	logic [RMA_VAR_W-1:0]   owner_rd;
	logic                   dirty_rd;
	logic                   is_last_reg;
	logic                   hit;
	logic                   cur_free;
	logic                   any_free;
	logic                   avoid_hit;
	logic                   out_free;
	logic                   accept;
	logic                   emit;
	logic [RMA_KIND_W-1:0]  e_kind;
	logic [RMA_REG_W-1:0]   e_reg;
	logic                   e_zero;
	logic [RMA_OFF_W-1:0]   e_off;
	logic                   e_last;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [RMA_ENTRY_W-1:0] ram_wdata;
	logic [RMA_ENTRY_W-1:0] ram_rdata;
	logic [RMA_SLOT_W-1:0]  slot_sel;
	logic [RIW-1:0]         rem_idx;
	logic [RIW-1:0]         victim_idx;
	logic                   svar_big;
	rma_div_ctl_t           div_ctl;
	rma_div_st_t            div_st;

	rma_victim_div #(
		.NUM_REGS(NUM_REGS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (div_ctl),
		.seed  (seed_q),
		.st    (div_st)
	);

	rma_ram #(
		.WIDTH(RMA_ENTRY_W),
		.DEPTH(NUM_VARS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(AW'(svar_q)),
		.rdata(ram_rdata)
	);

	assign owner_rd    = owner_q[idx_q];
	assign dirty_rd    = dirty_q[idx_q];
	assign is_last_reg = (idx_q == LAST_REG);
	assign hit         = (owner_rd == var_q);
	assign cur_free    = (owner_rd == '0);
	assign any_free    = free_found_q || cur_free;
	assign avoid_hit   = (cmd_q == CMD_ENSURE_AVOID) && (avar_q != '0) && (owner_rd == avar_q);
	assign out_free    = !out_valid_q || result.ready;
	assign accept      = request.valid && request.ready;
	assign slot_sel    = ram_rdata[RMA_ENTRY_W-1] ? ram_rdata[RMA_SLOT_W-1:0] : next_slot_q;
	assign rem_idx     = div_st.rem[RIW-1:0];
	assign victim_idx  = (avoid_found_q && (rem_idx == avoid_idx_q)) ?
		((rem_idx == LAST_REG) ? '0 : rem_idx + 1'b1) : rem_idx;
	assign svar_big    = (13'(svar_q) >= NV_CMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		request.ready = 1'b0;
		div_ctl       = '0;
		emit          = 1'b0;
		e_kind        = KIND_ANSWER;
		e_reg         = RMA_REG_W'(idx_q);
		e_zero        = 1'b0;
		e_off         = '0;
		e_last        = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = AW'(svar_q);
		ram_wdata     = {1'b1, next_slot_q};
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == LAST_VAR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				request.ready = 1'b1;
				if (request.valid) begin
					case (request.cmd)
						CMD_CLEAR_MAP: div_ctl.reseed = 1'b1;
						CMD_FLUSH:     state_d = ST_FSCAN;
						default: begin
							state_d = (request.var_id == '0) ? ST_ANSWER : ST_SCAN;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = ST_ANSWER;
				end else if (is_last_reg) begin
					if (any_free) begin
						state_d = ST_ALLOC;
					end else begin
						div_ctl.start = 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_st.done) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX:   state_d = ST_VSEL;
			ST_VSEL:  state_d = ST_MOD;
			ST_ALLOC: state_d = wr_q ? ST_ANSWER : ST_MOD;
			ST_MOD: begin
				if (!svar_big) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				ram_we  = !ram_rdata[RMA_ENTRY_W-1];
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit   = 1'b1;
					e_kind = (phase_q == PH_LOAD) ? KIND_LOAD : KIND_STORE;
					e_off  = off_q;
					case (phase_q)
						PH_VICTIM: state_d = wr_q ? ST_ANSWER : ST_MOD;
						PH_LOAD:   state_d = ST_ANSWER;
						default:   state_d = is_last_reg ? ST_FDONE : ST_FSCAN;
					endcase
				end
			end
			ST_ANSWER: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_ANSWER;
					e_reg   = zero_q ? '0 : RMA_REG_W'(idx_q);
					e_zero  = zero_q;
					e_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_FSCAN: begin
				if (dirty_rd) begin
					state_d = ST_MOD;
				end else if (is_last_reg) begin
					state_d = ST_FDONE;
				end
			end
			ST_FDONE: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_FLUSHED;
					e_reg   = '0;
					e_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				owner_q[i] <= '0;
			end
			dirty_q     <= '0;
			next_slot_q <= '0;
			clr_q       <= '0;
			seed_q      <= RMA_LFSR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (accept && (request.cmd == CMD_CLEAR_MAP)) begin
						for (int i = 0; i < NUM_REGS; i++) begin
							owner_q[i] <= '0;
						end
						dirty_q <= '0;
					end
				end
				ST_SCAN: begin
					if (hit && wr_q) begin
						dirty_q[idx_q] <= 1'b1;
					end
				end
				ST_ALLOC: begin
					owner_q[idx_q] <= var_q;
					dirty_q[idx_q] <= wr_q;
				end
				ST_WAIT: begin
					if (!ram_rdata[RMA_ENTRY_W-1]) begin
						next_slot_q <= next_slot_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						case (phase_q)
							PH_VICTIM: begin
								owner_q[idx_q] <= var_q;
								dirty_q[idx_q] <= wr_q;
							end
							PH_FLUSH: dirty_q[idx_q] <= 1'b0;
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= e_kind;
			out_reg_q  <= e_reg;
			out_zero_q <= e_zero;
			out_off_q  <= e_off;
			out_last_q <= e_last;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q         <= request.cmd;
					var_q         <= request.var_id;
					wr_q          <= request.is_write;
					avar_q        <= request.avoid_var_id;
					zero_q        <= (request.var_id == '0);
					idx_q         <= '0;
					free_found_q  <= 1'b0;
					avoid_found_q <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (!hit) begin
					if (cur_free && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q;
					end
					if (avoid_hit) begin
						avoid_found_q <= 1'b1;
						avoid_idx_q   <= idx_q;
					end
					if (is_last_reg) begin
						if (any_free) begin
							idx_q <= free_found_q ? free_idx_q : idx_q;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
			ST_FIX: idx_q <= victim_idx;
			ST_VSEL: begin
				svar_q  <= owner_rd;
				phase_q <= PH_VICTIM;
			end
			ST_ALLOC: begin
				svar_q  <= var_q;
				phase_q <= PH_LOAD;
			end
			ST_MOD: begin
				if (svar_big) begin
					svar_q <= svar_q - NV_SUB;
				end
			end
			ST_WAIT: begin
				off_q <= 11'd0 - (({3'b000, slot_sel} + 11'd1) << 2);
			end
			ST_EMIT: begin
				if (out_free) begin
					case (phase_q)
						PH_VICTIM: begin
							svar_q  <= var_q;
							phase_q <= PH_LOAD;
						end
						PH_FLUSH: begin
							if (!is_last_reg) begin
								idx_q <= idx_q + 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FSCAN: begin
				if (dirty_rd) begin
					svar_q  <= owner_rd;
					phase_q <= PH_FLUSH;
				end else if (!is_last_reg) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign result.valid        = out_valid_q;
	assign result.kind         = out_kind_q;
	assign result.reg_index    = out_reg_q;
	assign result.use_zero     = out_zero_q;
	assign result.frame_offset = out_off_q;
	assign result.last         = out_last_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the register map allocator with random handshakes and its own predictor.
module tb_top;
	import rma_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_WAIT  = 100;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 60;
	localparam int PHASE_ITEMS  = 115;

	typedef struct packed {
		logic [RMA_CMD_W-1:0] cmd;
		logic [RMA_VAR_W-1:0] var_id;
		logic                 is_write;
		logic [RMA_VAR_W-1:0] avoid_var_id;
	} alloc_req_t;

	typedef struct packed {
		logic [RMA_KIND_W-1:0]       kind;
		logic [RMA_REG_W-1:0]        reg_index;
		logic                        use_zero;
		logic signed [RMA_OFF_W-1:0] frame_offset;
		logic                        last;
	} alloc_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [RMA_SEED_W-1:0] cfg_wdata;

	rma_in_if  req_ch ();
	rma_out_if res_ch ();

	register_map_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (req_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_HALF) clk = ~clk;

	alloc_req_t    pending_reqs [$];
	alloc_result_t owed_results [$];
	alloc_req_t    next_req;
	alloc_result_t got_result;
	alloc_result_t want_result;

	logic [RMA_VAR_W-1:0]  map_owner [RMA_NUM_REGS];
	logic                  map_dirty [RMA_NUM_REGS];
	logic                  slot_taken [RMA_NUM_VARS];
	logic [RMA_SLOT_W-1:0] slot_num [RMA_NUM_VARS];
	logic [RMA_SLOT_W-1:0] slot_next;
	logic [RMA_SEED_W-1:0] vic_lfsr;
	logic [RMA_SEED_W-1:0] vic_seed;

	int send_idle_pct;
	int recv_idle_pct;
	int errors = 0;
	int results_seen = 0;
	int hold_left;
	logic hold_done;
	int cycles = 0;

	function automatic void owe(logic [RMA_KIND_W-1:0] kind, int reg_no, logic zero,
			logic signed [RMA_OFF_W-1:0] off, logic fin);
		alloc_result_t res;
		res.kind         = kind;
		res.reg_index    = reg_no[RMA_REG_W-1:0];
		res.use_zero     = zero;
		res.frame_offset = off;
		res.last         = fin;
		owed_results.push_back(res);
	endfunction

	// Slots are handed out on first use, each one word further below the frame pointer.
	function automatic logic signed [RMA_OFF_W-1:0] frame_slot(logic [RMA_VAR_W-1:0] v);
		int off;
		if (!slot_taken[v]) begin
			slot_taken[v] = 1'b1;
			slot_num[v]   = slot_next;
			slot_next     = slot_next + 1'b1;
		end
		off = -4 * (int'(slot_num[v]) + 1);
		return off[RMA_OFF_W-1:0];
	endfunction

	function automatic int find_owner(logic [RMA_VAR_W-1:0] v);
		for (int i = 0; i < RMA_NUM_REGS; i++) begin
			if (map_owner[i] != 0 && map_owner[i] == v)
				return i;
		end
		return -1;
	endfunction

	function automatic void allocate_step(alloc_req_t q);
		int r;
		int avoid;
		logic [RMA_SEED_W-1:0] l;
		if (q.cmd == CMD_CLEAR_MAP) begin
			for (int i = 0; i < RMA_NUM_REGS; i++) begin
				map_owner[i] = '0;
				map_dirty[i] = 1'b0;
			end
			vic_lfsr = (vic_seed != 0) ? vic_seed : RMA_LFSR_RESET;
			return;
		end
		if (q.cmd == CMD_FLUSH) begin
			for (int i = 0; i < RMA_NUM_REGS; i++) begin
				if (map_dirty[i]) begin
					owe(KIND_STORE, i, 1'b0, frame_slot(map_owner[i]), 1'b0);
					map_dirty[i] = 1'b0;
				end
			end
			owe(KIND_FLUSHED, 0, 1'b0, '0, 1'b1);
			return;
		end
		if (q.var_id == 0) begin
			owe(KIND_ANSWER, 0, 1'b1, '0, 1'b1);
			return;
		end
		r = find_owner(q.var_id);
		if (r >= 0) begin
			if (q.is_write)
				map_dirty[r] = 1'b1;
		end else begin
			for (int i = 0; i < RMA_NUM_REGS; i++) begin
				if (r < 0 && map_owner[i] == 0)
					r = i;
			end
			if (r < 0) begin
				avoid = (q.cmd == CMD_ENSURE_AVOID && q.avoid_var_id != 0) ?
					find_owner(q.avoid_var_id) : -1;
				l = vic_lfsr;
				vic_lfsr = {1'b0, l[RMA_SEED_W-1:1]} ^ (l[0] ? RMA_LFSR_MASK : '0);
				r = int'(vic_lfsr) % RMA_NUM_REGS;
				if (r == avoid)
					r = (r + 1) % RMA_NUM_REGS;
				owe(KIND_STORE, r, 1'b0, frame_slot(map_owner[r]), 1'b0);
			end
			map_owner[r] = q.var_id;
			map_dirty[r] = q.is_write;
			if (!q.is_write)
				owe(KIND_LOAD, r, 1'b0, frame_slot(q.var_id), 1'b0);
		end
		owe(KIND_ANSWER, r, 1'b0, '0, 1'b1);
	endfunction

	function automatic void field_check(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function automatic void queue_req(logic [RMA_CMD_W-1:0] cmd, int v, logic wr, int av);
		alloc_req_t q;
		q.cmd          = cmd;
		q.var_id       = v[RMA_VAR_W-1:0];
		q.is_write     = wr;
		q.avoid_var_id = av[RMA_VAR_W-1:0];
		pending_reqs.push_back(q);
	endfunction

	// A small working set of variables keeps the map full so that evictions dominate.
	function automatic void queue_random_req();
		int pick;
		int v;
		int av;
		logic [RMA_CMD_W-1:0] cmd;
		pick = $urandom_range(99);
		if (pick < 45)
			cmd = CMD_ENSURE;
		else if (pick < 80)
			cmd = CMD_ENSURE_AVOID;
		else if (pick < 93)
			cmd = CMD_FLUSH;
		else
			cmd = CMD_CLEAR_MAP;
		pick = $urandom_range(99);
		if (pick < 6)
			v = 0;
		else if (pick < 88)
			v = $urandom_range(28, 1);
		else
			v = $urandom_range(255);
		pick = $urandom_range(99);
		if (pick < 10)
			av = 0;
		else if (pick < 80)
			av = $urandom_range(28, 1);
		else
			av = $urandom_range(255);
		queue_req(cmd, v, $urandom_range(99) < 40, av);
	endfunction

	task automatic settle();
		while (pending_reqs.size() != 0 || req_ch.valid || owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic write_seed(logic [RMA_SEED_W-1:0] seed);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= seed;
		vic_seed  = seed;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid        <= 1'b0;
			req_ch.cmd          <= CMD_ENSURE;
			req_ch.var_id       <= '0;
			req_ch.is_write     <= 1'b0;
			req_ch.avoid_var_id <= '0;
			for (int i = 0; i < RMA_NUM_REGS; i++) begin
				map_owner[i] = '0;
				map_dirty[i] = 1'b0;
			end
			for (int i = 0; i < RMA_NUM_VARS; i++) begin
				slot_taken[i] = 1'b0;
				slot_num[i]   = '0;
			end
			slot_next = '0;
			vic_lfsr  = RMA_LFSR_RESET;
		end else begin
			if (req_ch.valid && req_ch.ready)
				allocate_step({req_ch.cmd, req_ch.var_id, req_ch.is_write, req_ch.avoid_var_id});
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_reqs.pop_front();
					req_ch.valid        <= 1'b1;
					req_ch.cmd          <= next_req.cmd;
					req_ch.var_id       <= next_req.var_id;
					req_ch.is_write     <= next_req.is_write;
					req_ch.avoid_var_id <= next_req.avoid_var_id;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got_result = {res_ch.kind, res_ch.reg_index, res_ch.use_zero,
					res_ch.frame_offset, res_ch.last};
				if (owed_results.size() == 0) begin
					$error("unexpected result: kind %0d, reg_index %0d", got_result.kind,
						got_result.reg_index);
					errors++;
				end else begin
					want_result = owed_results.pop_front();
					field_check("kind", want_result.kind, got_result.kind);
					field_check("reg_index", want_result.reg_index, got_result.reg_index);
					field_check("use_zero", want_result.use_zero, got_result.use_zero);
					field_check("frame_offset", want_result.frame_offset,
						got_result.frame_offset);
					field_check("last", want_result.last, got_result.last);
				end
				results_seen++;
			end
			if (hold_left != 0) begin
				res_ch.ready <= 1'b0;
				hold_left    <= hold_left - 1;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				res_ch.ready <= 1'b0;
				hold_left    <= HOLD_CYCLES;
				hold_done    <= 1'b1;
			end else begin
				res_ch.ready <= $urandom_range(99) >= recv_idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		send_idle_pct       = 16;
		recv_idle_pct       = 73;
		vic_seed            = RMA_LFSR_RESET;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_seed(16'hFFFF);

		queue_req(CMD_ENSURE, 0, 1'b0, 0);
		queue_req(CMD_ENSURE_AVOID, 0, 1'b1, 5);
		queue_req(CMD_FLUSH, 0, 1'b0, 0);
		queue_req(CMD_ENSURE, 255, 1'b1, 0);
		queue_req(CMD_ENSURE, 1, 1'b0, 0);
		queue_req(CMD_ENSURE, 1, 1'b1, 0);
		queue_req(CMD_FLUSH, 0, 1'b0, 0);
		for (int v = 2; v < 18; v++)
			queue_req(CMD_ENSURE, v, v[0], 0);
		queue_req(CMD_ENSURE_AVOID, 100, 1'b0, 255);
		queue_req(CMD_ENSURE_AVOID, 101, 1'b1, 0);
		queue_req(CMD_ENSURE_AVOID, 102, 1'b0, 200);
		queue_req(CMD_CLEAR_MAP, 0, 1'b0, 0);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				settle();
				write_seed(16'h0000);
				send_idle_pct = 73;
				recv_idle_pct = 16;
			end else if (phase == 2) begin
				settle();
				write_seed(16'h0001);
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			queue_req(CMD_CLEAR_MAP, 0, 1'b0, 0);
			for (int n = 0; n < PHASE_ITEMS; n++)
				queue_random_req();
		end
		settle();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
